@@ rtl/core/pdacc_pkg.sv @@
// types, constants and control records for the polarization detect/accumulate block
// no dependencies
`timescale 1ns / 1ps

package pdacc_pkg;

  localparam int NUM_CHANNELS_DEF = 32;
  localparam int SAMPLE_BITS      = 16;
  localparam int ACC_BITS         = 56;
  localparam int PROD_BITS        = 2 * SAMPLE_BITS;
  localparam int DET_BITS         = PROD_BITS + 1;
  localparam int VAL_BITS         = PROD_BITS + 3;
  localparam int MAG_BITS         = PROD_BITS + 1;
  localparam int NORM_BITS        = 2 * MAG_BITS;
  localparam int ROOT_STEPS       = MAG_BITS;
  localparam int REM_BITS         = MAG_BITS + 3;
  localparam int CNT_BITS         = $clog2(ROOT_STEPS + 1);

  localparam logic [2:0] MODE_COH  = 3'd0;
  localparam logic [2:0] MODE_INT  = 3'd1;
  localparam logic [2:0] MODE_XPW  = 3'd2;
  localparam logic [2:0] MODE_YPW  = 3'd3;
  localparam logic [2:0] MODE_STK  = 3'd4;
  localparam logic [2:0] MODE_MAG  = 3'd5;

  typedef struct packed {
    logic signed [15:0] pol0_real;
    logic signed [15:0] pol0_imag;
    logic signed [15:0] pol1_real;
    logic signed [15:0] pol1_imag;
    logic [4:0]         channel;
    logic               half_weight;
    logic               frame_start;
    logic               frame_end;
  } bin_t;

  typedef struct packed {
    logic [4:0]         out_channel;
    logic signed [55:0] sum0;
    logic signed [55:0] sum1;
    logic signed [55:0] sum2;
    logic signed [55:0] sum3;
    logic               saturated;
    logic               last;
  } result_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic sum;
    logic det;
    logic sq_init;
    logic sq_step;
    logic rt_init;
    logic rt_step;
    logic add;
    logic dump_first;
    logic dump_rd;
    logic dump_ld;
    logic dump_next;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_mag;
    logic frame_end;
    logic dump_last;
  } ctl_stat_t;

endpackage

@@ rtl/core/polarization_detect_accumulate_top.sv @@
// top level: polarization detection with per-channel saturating accumulation
// depends on pdacc_pkg, pdacc_ctrl, pdacc_datapath
// order: capture, multiply, sum, detect, write; magnitude mode adds two 33-step loops of the magnitude unit
// input: stall is high while a bin is at work or a dump runs; no new bin is taken before the last is done
// frame end: after the bin, the dump reads each channel once from the accumulator memory and outputs it
// reset: synchronous, clears mode to coherence and all valid and clip flags (accumulators read zero); no clearing pass
`timescale 1ns / 1ps

module polarization_detect_accumulate_top #(
  parameter int NUM_CHANNELS = pdacc_pkg::NUM_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pdacc_pkg::bin_t     bin,
  input  logic                bin_valid,
  output logic                bin_stall,
  output pdacc_pkg::result_t  result,
  output logic                result_valid,
  input  logic                result_stall,
  input  logic [2:0]          cfg_data,
  input  logic                cfg_valid,
  output logic                cfg_ready
);
  import pdacc_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  assign cfg_ready = 1'b1;

  pdacc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .bin_valid    (bin_valid),
    .bin_stall    (bin_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  pdacc_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .bin      (bin),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

endmodule

@@ rtl/core/pdacc_datapath.sv @@
// datapath: products, detection terms, magnitude unit, accumulator memory, output register
// depends on pdacc_pkg
`timescale 1ns / 1ps

module pdacc_datapath #(
  parameter int NUM_CHANNELS = pdacc_pkg::NUM_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pdacc_pkg::bin_t     bin,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_data,
  input  pdacc_pkg::ctl_cmd_t cmd,
  output pdacc_pkg::ctl_stat_t stat,
  output pdacc_pkg::result_t  result
);
  import pdacc_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef logic [3:0][ACC_BITS-1:0] row_t;

  logic [2:0] mode;
  bin_t       cur;

  logic signed [PROD_BITS-1:0] p_r0r0, p_i0i0, p_r1r1, p_i1i1;
  logic signed [PROD_BITS-1:0] p_r0r1, p_i0i1, p_r0i1, p_i0r1;
  logic signed [DET_BITS-1:0]  xx, yy, re, im;
  logic signed [VAL_BITS-1:0]  term [4];
  logic signed [VAL_BITS-2:0]  dq, du;

  logic [MAG_BITS-1:0]  qb, ub, root;
  logic [NORM_BITS-1:0] qm, um, norm, nsh;
  logic [REM_BITS-1:0]  rem;

  row_t                  mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;
  logic [NUM_CHANNELS-1:0] clip;
  row_t                  rd;
  logic                  rd_v;
  logic [AW-1:0]         k;
  logic [AW-1:0]         cidx;
  logic [AW-1:0]         rd_addr;
  logic                  ch_ok;

  logic [MAG_BITS-1:0]   q_abs, u_abs;
  logic [REM_BITS-1:0]   rem_sh, trial;
  row_t                  new_row;
  logic                  any_clip;

  assign cidx    = AW'(cur.channel);
  assign ch_ok   = 32'(cur.channel) < NUM_CHANNELS;
  assign rd_addr = cmd.dump_rd ? k : cidx;

  assign stat.is_mag    = (mode == MODE_MAG);
  assign stat.frame_end = cur.frame_end;
  assign stat.dump_last = (k == AW'(NUM_CHANNELS - 1));

  assign q_abs = dq[VAL_BITS-2] ? MAG_BITS'(-dq) : MAG_BITS'(dq);
  assign u_abs = du[VAL_BITS-2] ? MAG_BITS'(-du) : MAG_BITS'(du);

  assign rem_sh = {rem[REM_BITS-3:0], nsh[NORM_BITS-1 -: 2]};
  assign trial  = REM_BITS'({root, 2'b01});

  // saturating add of the detected terms into the channel row
  always_comb begin
    logic signed [VAL_BITS-1:0] v;
    logic signed [ACC_BITS-1:0] a;
    logic signed [ACC_BITS:0]   s;
    any_clip = 1'b0;
    new_row  = '0;
    for (int j = 0; j < 4; j++) begin
      v = (j == 0 && stat.is_mag) ? VAL_BITS'(root) : term[j];
      if (cur.half_weight) begin
        v = v >>> 1;
      end
      a = rd_v ? $signed(rd[j]) : '0;
      s = (ACC_BITS + 1)'(a) + (ACC_BITS + 1)'(v);
      if (s[ACC_BITS:ACC_BITS-1] == 2'b01) begin
        new_row[j] = {1'b0, {(ACC_BITS - 1){1'b1}}};
        any_clip   = 1'b1;
      end else if (s[ACC_BITS:ACC_BITS-1] == 2'b10) begin
        new_row[j] = {1'b1, {(ACC_BITS - 1){1'b0}}};
        any_clip   = 1'b1;
      end else begin
        new_row[j] = s[ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_COH;
      vld  <= '0;
      clip <= '0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_data;
      end
      if (cmd.capture && bin.frame_start) begin
        vld  <= '0;
        clip <= '0;
      end
      if (cmd.add && ch_ok) begin
        vld[cidx]  <= 1'b1;
        clip[cidx] <= clip[cidx] | any_clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && ch_ok) begin
      mem[cidx] <= new_row;
    end
    if (cmd.mul || cmd.dump_rd) begin
      rd   <= mem[rd_addr];
      rd_v <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= bin;
    end
    if (cmd.mul) begin
      p_r0r0 <= cur.pol0_real * cur.pol0_real;
      p_i0i0 <= cur.pol0_imag * cur.pol0_imag;
      p_r1r1 <= cur.pol1_real * cur.pol1_real;
      p_i1i1 <= cur.pol1_imag * cur.pol1_imag;
      p_r0r1 <= cur.pol0_real * cur.pol1_real;
      p_i0i1 <= cur.pol0_imag * cur.pol1_imag;
      p_r0i1 <= cur.pol0_real * cur.pol1_imag;
      p_i0r1 <= cur.pol0_imag * cur.pol1_real;
    end
    if (cmd.sum) begin
      xx <= DET_BITS'(p_r0r0) + DET_BITS'(p_i0i0);
      yy <= DET_BITS'(p_r1r1) + DET_BITS'(p_i1i1);
      re <= DET_BITS'(p_r0r1) + DET_BITS'(p_i0i1);
      im <= DET_BITS'(p_r0i1) - DET_BITS'(p_i0r1);
    end
    if (cmd.det) begin
      dq <= (VAL_BITS - 1)'(xx) - (VAL_BITS - 1)'(yy);
      du <= (VAL_BITS - 1)'(re) <<< 1;
      unique case (mode)
        MODE_COH: begin
          term[0] <= VAL_BITS'(xx);
          term[1] <= VAL_BITS'(yy);
          term[2] <= VAL_BITS'(re);
          term[3] <= VAL_BITS'(im);
        end
        MODE_INT: begin
          term[0] <= VAL_BITS'(xx) + VAL_BITS'(yy);
          term[1] <= '0;
          term[2] <= '0;
          term[3] <= '0;
        end
        MODE_XPW: begin
          term[0] <= VAL_BITS'(xx);
          term[1] <= '0;
          term[2] <= '0;
          term[3] <= '0;
        end
        MODE_YPW: begin
          term[0] <= VAL_BITS'(yy);
          term[1] <= '0;
          term[2] <= '0;
          term[3] <= '0;
        end
        MODE_STK: begin
          term[0] <= VAL_BITS'(xx) + VAL_BITS'(yy);
          term[1] <= VAL_BITS'(xx) - VAL_BITS'(yy);
          term[2] <= VAL_BITS'(re) <<< 1;
          term[3] <= VAL_BITS'(im) <<< 1;
        end
        MODE_MAG: begin
          term[0] <= '0;
          term[1] <= VAL_BITS'(im) <<< 1;
          term[2] <= '0;
          term[3] <= '0;
        end
        default: begin
          term[0] <= '0;
          term[1] <= '0;
          term[2] <= '0;
          term[3] <= '0;
        end
      endcase
    end
    // shift-add squares of the two magnitudes
    if (cmd.sq_init) begin
      qb   <= q_abs;
      ub   <= u_abs;
      qm   <= NORM_BITS'(q_abs);
      um   <= NORM_BITS'(u_abs);
      norm <= '0;
    end
    if (cmd.sq_step) begin
      norm <= norm + (qb[0] ? qm : '0) + (ub[0] ? um : '0);
      qb   <= qb >> 1;
      ub   <= ub >> 1;
      qm   <= qm << 1;
      um   <= um << 1;
    end
    // digit-by-digit square root
    if (cmd.rt_init) begin
      nsh  <= norm;
      root <= '0;
      rem  <= '0;
    end
    if (cmd.rt_step) begin
      nsh <= nsh << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[MAG_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[MAG_BITS-2:0], 1'b0};
      end
    end
    if (cmd.dump_first) begin
      k <= '0;
    end
    if (cmd.dump_next) begin
      k <= k + 1'b1;
    end
    if (cmd.dump_ld) begin
      result.out_channel <= 5'(k);
      result.sum0        <= rd_v ? $signed(rd[0]) : '0;
      result.sum1        <= rd_v ? $signed(rd[1]) : '0;
      result.sum2        <= rd_v ? $signed(rd[2]) : '0;
      result.sum3        <= rd_v ? $signed(rd[3]) : '0;
      result.saturated   <= clip[k];
      result.last        <= stat.dump_last;
    end
  end

endmodule

@@ rtl/core/pdacc_ctrl.sv @@
// controller: sequences one bin through the datapath and runs the frame-end dump
// depends on pdacc_pkg
`timescale 1ns / 1ps

module pdacc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 bin_valid,
  output logic                 bin_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  pdacc_pkg::ctl_stat_t stat,
  output pdacc_pkg::ctl_cmd_t  cmd
);
  import pdacc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_DET, S_SQI, S_SQ, S_RTI, S_RT, S_ADD, S_DRD, S_DLD, S_DOUT
  } state_t;

  state_t              state;
  logic [CNT_BITS-1:0] cnt;

  assign bin_stall    = (state != S_IDLE);
  assign result_valid = (state == S_DOUT);

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == S_IDLE) && bin_valid;
    cmd.mul        = (state == S_MUL);
    cmd.sum        = (state == S_SUM);
    cmd.det        = (state == S_DET);
    cmd.sq_init    = (state == S_SQI);
    cmd.sq_step    = (state == S_SQ);
    cmd.rt_init    = (state == S_RTI);
    cmd.rt_step    = (state == S_RT);
    cmd.add        = (state == S_ADD);
    cmd.dump_first = (state == S_ADD);
    cmd.dump_rd    = (state == S_DRD);
    cmd.dump_ld    = (state == S_DLD);
    cmd.dump_next  = (state == S_DOUT) && !result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (bin_valid) state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_DET;
        S_DET:  state <= stat.is_mag ? S_SQI : S_ADD;
        S_SQI: begin
          cnt   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_BITS'(ROOT_STEPS - 1)) state <= S_RTI;
        end
        S_RTI: begin
          cnt   <= '0;
          state <= S_RT;
        end
        S_RT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_BITS'(ROOT_STEPS - 1)) state <= S_ADD;
        end
        S_ADD:  state <= stat.frame_end ? S_DRD : S_IDLE;
        S_DRD:  state <= S_DLD;
        S_DLD:  state <= S_DOUT;
        S_DOUT: begin
          if (!result_stall) state <= stat.dump_last ? S_IDLE : S_DRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_bin_in_dump: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> bin_stall) else $error("bin taken during dump");
  a_one_bin: assert property (@(posedge clk) disable iff (rst)
    (bin_valid && !bin_stall) |=> bin_stall) else $error("second bin taken while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ || state == S_RT) |-> cnt < CNT_BITS'(ROOT_STEPS))
    else $error("iteration count overrun");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid) else $error("result dropped");

endmodule
